/* src/smsw_pkg.sv */
// Shared widths, kernel constants and helper functions of the smoothing weight pipeline.
`default_nettype none
package smsw_pkg;

  localparam int unsigned NUM_AXES     = 3;
  localparam int unsigned IN_W         = 19;
  localparam int unsigned OUT_W        = 25;
  localparam int unsigned A_W          = 18;
  localparam int unsigned ACC_W        = 40;
  localparam int unsigned PROD_W       = ACC_W + A_W + 1;
  localparam int unsigned FRAC_SHIFT   = 16;
  localparam int unsigned W_SHIFT      = 8;
  localparam int unsigned P_SHIFT      = 24;
  localparam int unsigned SAT_IN_W     = 32;
  localparam int unsigned T_W          = OUT_W + 1;
  localparam int unsigned P1_W         = 2 * OUT_W;
  localparam int unsigned P2_W         = T_W + OUT_W;
  localparam int unsigned HORNER_STEPS = 8;
  localparam int unsigned NUM_STAGES   = HORNER_STEPS + 4;
  localparam int unsigned STEP_W       = 4;
  localparam int unsigned IN_TDATA_W   = 64;
  localparam int unsigned OUT_TDATA_W  = 104;

  localparam logic signed [IN_W-1:0] ONE_IN = IN_W'(1 << FRAC_SHIFT);
  localparam logic signed [IN_W-1:0] TWO_IN = IN_W'(2 << FRAC_SHIFT);

  localparam logic signed [SAT_IN_W-1:0] W_MAX = SAT_IN_W'(64'd16777215);
  localparam logic signed [SAT_IN_W-1:0] W_MIN = -SAT_IN_W'(64'd16777216);

  localparam logic signed [ACC_W-1:0] Q_ONE  = ACC_W'(64'd1 << 32);
  localparam logic signed [ACC_W-1:0] K_1024 = ACC_W'(64'd15 << 22);
  localparam logic signed [ACC_W-1:0] K_128  = ACC_W'(64'd15 << 25);
  localparam logic signed [ACC_W-1:0] K_49   = ACC_W'(64'd49 << 25);
  localparam logic signed [ACC_W-1:0] K_21   = ACC_W'(64'd21 << 27);
  localparam logic signed [ACC_W-1:0] K_35   = ACC_W'(64'd35 << 26);
  localparam logic signed [ACC_W-1:0] K_7    = ACC_W'(64'd7 << 28);
  localparam logic signed [ACC_W-1:0] K_175  = ACC_W'(64'd175 << 24);
  localparam logic signed [ACC_W-1:0] K_105  = ACC_W'(64'd105 << 25);
  localparam logic signed [ACC_W-1:0] K_337  = ACC_W'(64'd337 << 23);

  // Constant added after the multiply of the given Horner step.
  function automatic logic signed [ACC_W-1:0] horner_add(input logic [STEP_W-1:0] step,
                                                          input logic outer);
    logic signed [ACC_W-1:0] add;
    case (step)
      4'd1:    add = -K_128;
      4'd2:    add = outer ? K_49 : K_7;
      4'd3:    add = -K_21;
      4'd4:    add = outer ? K_35 : K_175;
      4'd6:    add = outer ? '0 : -K_105;
      4'd7:    add = outer ? -Q_ONE : '0;
      4'd8:    add = outer ? Q_ONE : K_337;
      default: add = '0;
    endcase
    return add;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_w(input logic signed [SAT_IN_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > W_MAX) begin
      r = OUT_W'(W_MAX);
    end else if (v < W_MIN) begin
      r = OUT_W'(W_MIN);
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/smooth_shape_weight_3d.sv */
// Top level: pipelined three-axis smoothing kernel weights and their product.
//
// One transaction on the slave stream carries an offset triple (particle minus
// vertex, Q16) and yields exactly one transaction on the master stream with
// the three axis weights and their product (Q24). Each axis has an input stage
// that takes the magnitude and picks the band, then its own lane of eight
// Horner stages, one multiply and add per stage. A scaling and saturation
// stage and two stages for the product follow, twelve register stages in all.
// Throughput is one transaction per cycle while the receiver is ready, since
// every stage then passes its item on and takes a new one.
// Every stage carries a valid bit and loads only when its successor can take
// its contents, so empty stages fill up while the receiver stalls and the
// block keeps accepting until the pipeline is full. A stalled output holds
// its data steady. Reset clears all valid bits; the pipeline is then empty
// and s_axis_tready_o is high.
`default_nettype none
module smooth_shape_weight_3d (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // dx_offset [18:0], dy_offset [37:19], dz_offset [56:38], zero [63:57]
  input  wire logic [smsw_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // weight_x [24:0], weight_y [49:25], weight_z [74:50], weight_product [99:75],
  // zero [103:100]
  output logic [smsw_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o
);

  localparam int unsigned NA = smsw_pkg::NUM_AXES;
  localparam int unsigned NS = smsw_pkg::NUM_STAGES;
  localparam int unsigned HS = smsw_pkg::HORNER_STEPS;

  logic [NS-1:0] valid_q;
  logic [NS:0]   rdy;

  logic signed [smsw_pkg::ACC_W-1:0]  acc_q  [0:HS][0:NA-1];
  logic signed [smsw_pkg::ACC_W-1:0]  acc_d  [0:HS][0:NA-1];
  logic        [smsw_pkg::A_W-1:0]    a_q    [0:HS][0:NA-1];
  logic        [smsw_pkg::A_W-1:0]    a_d    [0:NA-1];
  logic                               outer_q[0:HS][0:NA-1];
  logic                               outer_d[0:NA-1];
  logic                               far_q  [0:HS][0:NA-1];
  logic                               far_d  [0:NA-1];
  logic signed [smsw_pkg::IN_W-1:0]   x_in   [0:NA-1];
  logic signed [smsw_pkg::PROD_W-1:0] prod   [1:HS][0:NA-1];

  logic signed [smsw_pkg::SAT_IN_W-1:0] wsh    [0:NA-1];
  logic signed [smsw_pkg::OUT_W-1:0]    w9_d   [0:NA-1];
  logic signed [smsw_pkg::OUT_W-1:0]    w9_q   [0:NA-1];
  logic signed [smsw_pkg::OUT_W-1:0]    w10_q  [0:NA-1];
  logic signed [smsw_pkg::OUT_W-1:0]    w11_q  [0:NA-1];
  logic signed [smsw_pkg::P1_W-1:0]     p10;
  logic signed [smsw_pkg::T_W-1:0]      t_d;
  logic signed [smsw_pkg::T_W-1:0]      t_q;
  logic signed [smsw_pkg::P2_W-1:0]     p11;
  logic signed [smsw_pkg::OUT_W-1:0]    wp_d;
  logic signed [smsw_pkg::OUT_W-1:0]    wp_q;

  always_comb begin
    rdy[NS] = m_axis_tready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = valid_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int ax = 0; ax < NA; ax++) begin
      x_in[ax]    = s_axis_tdata_i[ax*smsw_pkg::IN_W +: smsw_pkg::IN_W];
      far_d[ax]   = (x_in[ax] > smsw_pkg::TWO_IN) || (x_in[ax] <= -smsw_pkg::TWO_IN);
      outer_d[ax] = (x_in[ax] > smsw_pkg::ONE_IN) || (x_in[ax] <= -smsw_pkg::ONE_IN);
      a_d[ax]     = x_in[ax][smsw_pkg::IN_W-1] ? smsw_pkg::A_W'(-x_in[ax])
                                               : smsw_pkg::A_W'(x_in[ax]);
      acc_d[0][ax] = outer_d[ax] ? smsw_pkg::K_1024 : -smsw_pkg::K_1024;
    end
    for (int k = 1; k <= HS; k++) begin
      for (int ax = 0; ax < NA; ax++) begin
        prod[k][ax]  = acc_q[k-1][ax] * $signed({1'b0, a_q[k-1][ax]});
        acc_d[k][ax] = smsw_pkg::ACC_W'(prod[k][ax] >>> smsw_pkg::FRAC_SHIFT)
                       + smsw_pkg::horner_add(smsw_pkg::STEP_W'(k), outer_q[k-1][ax]);
      end
    end
    for (int ax = 0; ax < NA; ax++) begin
      wsh[ax]  = smsw_pkg::SAT_IN_W'(acc_q[HS][ax] >>> smsw_pkg::W_SHIFT);
      w9_d[ax] = far_q[HS][ax] ? '0 : smsw_pkg::sat_w(wsh[ax]);
    end
    p10  = w9_q[0] * w9_q[1];
    t_d  = smsw_pkg::T_W'(p10 >>> smsw_pkg::P_SHIFT);
    p11  = t_q * w10_q[2];
    wp_d = smsw_pkg::sat_w(smsw_pkg::SAT_IN_W'(p11 >>> smsw_pkg::P_SHIFT));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int ax = 0; ax < NA; ax++) begin
        acc_q[0][ax]   <= acc_d[0][ax];
        a_q[0][ax]     <= a_d[ax];
        outer_q[0][ax] <= outer_d[ax];
        far_q[0][ax]   <= far_d[ax];
      end
    end
    for (int k = 1; k <= HS; k++) begin
      if (rdy[k]) begin
        for (int ax = 0; ax < NA; ax++) begin
          acc_q[k][ax]   <= acc_d[k][ax];
          a_q[k][ax]     <= a_q[k-1][ax];
          outer_q[k][ax] <= outer_q[k-1][ax];
          far_q[k][ax]   <= far_q[k-1][ax];
        end
      end
    end
    if (rdy[HS+1]) begin
      w9_q <= w9_d;
    end
    if (rdy[HS+2]) begin
      w10_q <= w9_q;
      t_q   <= t_d;
    end
    if (rdy[HS+3]) begin
      w11_q <= w10_q;
      wp_q  <= wp_d;
    end
  end

  assign m_axis_tdata_o = {4'b0000, wp_q, w11_q[2], w11_q[1], w11_q[0]};

endmodule
`default_nettype wire

/* src/smsw_checker.sv */
// Port-level checker for the smoothing weight pipeline and its bind statement.
`default_nettype none
module smsw_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid_i,
  input wire logic                                s_axis_tready_o,
  input wire logic [smsw_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input wire logic                                m_axis_tvalid_o,
  input wire logic                                m_axis_tready_i,
  input wire logic [smsw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  // A stalled output transaction stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output transaction changed");

  // Reset leaves the pipeline empty.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  // With the output stage empty, every stage can advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output stage is empty");

  // A ready receiver never back-pressures the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while receiver is ready");

endmodule

bind smooth_shape_weight_3d smsw_checker u_smsw_checker (.*);
`default_nettype wire
